// File: sv/msa_pkg.sv
// Package: shared types, constants and float compare helpers for the matrix structure analyzer.
`default_nettype none
package msa_pkg;
    localparam int MAX_ROWS_DEF = 32;
    localparam int MAX_COLS_DEF = 32;
    localparam int IDX_W = 5;
    localparam int SIZE_W = 6;

    localparam logic [1:0] CFG_ROW_TOTAL    = 2'd0;
    localparam logic [1:0] CFG_COLUMN_TOTAL = 2'd1;
    localparam logic [1:0] CFG_CONST_MODE   = 2'd2;

    localparam logic [1:0] KIND_ROW     = 2'd0;
    localparam logic [1:0] KIND_COLUMN  = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    localparam logic [63:0] DOUBLE_ONE = 64'h3FF0_0000_0000_0000;

    typedef struct packed {
        logic take;       // accept an element into the datapath
        logic col_emit;   // present the column flag at ccnt_reg
        logic sum_emit;   // present the summary
        logic clear;      // return the matrix state to reset values
    } msa_cmd_t;

    typedef struct packed {
        logic row_last;   // element at hand ends a row
        logic mat_last;   // element at hand ends the matrix
        logic col_last;   // column flag at hand is the last one
    } msa_stat_t;

    function automatic logic is_nan(input logic [63:0] b);
        is_nan = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
    endfunction

    function automatic logic is_zero(input logic [63:0] b);
        is_zero = (b[62:0] == 63'd0);
    endfunction

    function automatic logic feq(input logic [63:0] a, input logic [63:0] b);
        feq = !is_nan(a) && !is_nan(b) && ((a == b) || (is_zero(a) && is_zero(b)));
    endfunction
endpackage
`default_nettype wire

// File: sv/msa_datapath.sv
// Datapath: element scan, bandwidth and diagonal tracking, result register.
`default_nettype none
module msa_datapath #(
    parameter int MAX_ROWS = msa_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = msa_pkg::MAX_COLS_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic [63:0]              element_bits,
    input  wire logic [msa_pkg::SIZE_W-1:0] row_total,
    input  wire logic [msa_pkg::SIZE_W-1:0] column_total,
    input  wire logic                     constant_mode,
    input  wire msa_pkg::msa_cmd_t        cmd,
    output msa_pkg::msa_stat_t            stat,
    output logic [21:0]                   result
);
    localparam int W = msa_pkg::IDX_W;
    localparam int SIZE_W = msa_pkg::SIZE_W;

    logic [W-1:0] row_reg, col_reg, ccnt_reg;
    logic [31:0]  zmask_reg;
    logic         rzero_reg, dz_reg, d1_reg, ds_reg;
    logic [W-1:0] rlo_reg, rup_reg, lmax_reg, umax_reg;
    logic [63:0]  corner_reg;
    logic [W-1:0] rows_m1, cols_m1;
    logic         nz, diag;
    logic [W-1:0] rlo_next, rup_next;

    always_comb
    begin
        if (row_total == '0) rows_m1 = '0;
        else if (row_total > SIZE_W'(MAX_ROWS)) rows_m1 = W'(MAX_ROWS - 1);
        else rows_m1 = W'(row_total - 1'b1);
        if (column_total == '0) cols_m1 = '0;
        else if (column_total > SIZE_W'(MAX_COLS)) cols_m1 = W'(MAX_COLS - 1);
        else cols_m1 = W'(column_total - 1'b1);
    end

    assign nz   = !msa_pkg::is_zero(element_bits);
    assign diag = (row_reg == col_reg);
    assign stat.row_last = (col_reg == cols_m1);
    assign stat.mat_last = (col_reg == cols_m1) && (row_reg == rows_m1);
    assign stat.col_last = (ccnt_reg == cols_m1);

    always_comb
    begin
        rlo_next = rlo_reg;
        rup_next = rup_reg;
        if (nz && col_reg < row_reg && rlo_reg == '0) rlo_next = row_reg - col_reg;
        if (nz && col_reg > row_reg) rup_next = col_reg - row_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0; col_reg <= '0; ccnt_reg <= '0;
            zmask_reg <= '1; rzero_reg <= 1'b1;
            rlo_reg <= '0; rup_reg <= '0; lmax_reg <= '0; umax_reg <= '0;
            dz_reg <= 1'b1; d1_reg <= 1'b1; ds_reg <= 1'b1; corner_reg <= '0;
            result <= '0;
        end
        else if (cmd.clear)
        begin
            row_reg <= '0; col_reg <= '0; ccnt_reg <= '0;
            zmask_reg <= '1; rzero_reg <= 1'b1;
            rlo_reg <= '0; rup_reg <= '0; lmax_reg <= '0; umax_reg <= '0;
            dz_reg <= 1'b1; d1_reg <= 1'b1; ds_reg <= 1'b1; corner_reg <= '0;
            // The summary is taken from the finished matrix as its state is cleared.
            if (cmd.sum_emit)
            begin
                result <= {1'b1,
                           constant_mode && lmax_reg == '0 && umax_reg == '0 && ds_reg,
                           constant_mode && lmax_reg == '0 && umax_reg == '0 && d1_reg,
                           constant_mode && lmax_reg == '0 && umax_reg == '0 && dz_reg,
                           umax_reg, lmax_reg, 1'b0, 5'd0, msa_pkg::KIND_SUMMARY};
            end
        end
        else if (cmd.take)
        begin
            if (nz) zmask_reg[col_reg] <= 1'b0;
            if (diag)
            begin
                if (row_reg == '0) corner_reg <= element_bits;
                if (nz) dz_reg <= 1'b0;
                if (!msa_pkg::feq(element_bits, msa_pkg::DOUBLE_ONE)) d1_reg <= 1'b0;
                if (!msa_pkg::feq(element_bits,
                    (row_reg == '0) ? element_bits : corner_reg)) ds_reg <= 1'b0;
            end
            if (stat.row_last)
            begin
                if (rlo_next > lmax_reg) lmax_reg <= rlo_next;
                if (rup_next > umax_reg) umax_reg <= rup_next;
                // row flag: kind, position, zero flag in the low bits
                result <= {1'b0, 3'd0, 5'd0, 5'd0, rzero_reg && !nz,
                           row_reg, msa_pkg::KIND_ROW};
                rzero_reg <= 1'b1; rlo_reg <= '0; rup_reg <= '0;
                col_reg <= '0; ccnt_reg <= '0;
                row_reg <= row_reg + 1'b1;
            end
            else
            begin
                rzero_reg <= rzero_reg && !nz;
                rlo_reg <= rlo_next; rup_reg <= rup_next;
                col_reg <= col_reg + 1'b1;
            end
        end
        else if (cmd.col_emit)
        begin
            result <= {1'b0, 3'd0, 5'd0, 5'd0, zmask_reg[ccnt_reg],
                       ccnt_reg, msa_pkg::KIND_COLUMN};
            ccnt_reg <= ccnt_reg + 1'b1;
        end
    end
endmodule
`default_nettype wire

// File: sv/msa_ctrl.sv
// Controller: sequences element intake, column flag burst and summary.
`default_nettype none
module msa_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_clear,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              out_ready,
    output logic                   out_valid,
    input  wire msa_pkg::msa_stat_t stat,
    output msa_pkg::msa_cmd_t      cmd
);
    typedef enum logic [2:0] {
        S_SCAN = 3'b001,
        S_COLS = 3'b010,
        S_SUM  = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   ov_reg, ov_next;
    logic   free;

    assign free      = !ov_reg || out_ready;
    assign out_valid = ov_reg;
    assign in_ready  = (state_reg == S_SCAN) && free && !cfg_clear;

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        ov_next = ov_reg && !out_ready;
        unique case (state_reg)
            S_SCAN:
            begin
                if (in_valid && free)
                begin
                    cmd.take = 1'b1;
                    if (stat.row_last) ov_next = 1'b1;
                    if (stat.mat_last) state_next = S_COLS;
                end
            end
            S_COLS:
            begin
                if (free)
                begin
                    cmd.col_emit = 1'b1;
                    ov_next = 1'b1;
                    if (stat.col_last) state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                if (free)
                begin
                    cmd.sum_emit = 1'b1;
                    ov_next = 1'b1;
                    state_next = S_SCAN;
                end
            end
            default: state_next = S_SCAN;
        endcase
        if (state_reg == S_SUM && free) cmd.clear = 1'b1;
        // A register write restarts the matrix; nothing else moves that cycle.
        if (cfg_clear)
        begin
            cmd = '0;
            ov_next = ov_reg && !out_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_SCAN;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= cfg_clear ? S_SCAN : state_next;
            ov_reg <= ov_next;
        end
    end
endmodule
`default_nettype wire

// File: sv/matrix_structure_analyzer.sv
// Top level: matrix structure analyzer with stream ports and a write-only config port.
// A row flag is registered and shown the cycle after the row's last element is accepted.
// Elements are taken one per cycle while the output register is free; after the last element
// the column flags follow, one per cycle while it is free, then the summary, set by the controller.
// Output stalls hold the input side, since one output register carries every request.
// Reset (rst_n, asynchronous) returns all counters, masks and flags to their initial values.
`default_nettype none
module matrix_structure_analyzer #(
    parameter int MAX_ROWS = msa_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = msa_pkg::MAX_COLS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [5:0]  cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // element_bits
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // position[4:0], is_zero_line[5], lower_bandwidth[10:6], upper_bandwidth[15:11],
    // all_zero[16], identity[17], scalar_diag[18], zero fill to 24 bits
    output logic [23:0]      m_tdata,
    output logic [1:0]       m_tuser,   // result_kind
    output logic             m_tlast    // run_end
);
    logic [5:0] rows_reg, cols_reg;
    logic       cmode_reg;
    logic       cfg_hit;
    logic [21:0] result;
    msa_pkg::msa_cmd_t  cmd, ctrl_cmd;
    msa_pkg::msa_stat_t stat;

    // Any write to a known register restarts the matrix in progress.
    assign cfg_hit = cfg_we && (cfg_index == msa_pkg::CFG_ROW_TOTAL ||
                                cfg_index == msa_pkg::CFG_COLUMN_TOTAL ||
                                cfg_index == msa_pkg::CFG_CONST_MODE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= 6'd1;
            cols_reg <= 6'd1;
            cmode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                msa_pkg::CFG_ROW_TOTAL:    rows_reg <= cfg_data;
                msa_pkg::CFG_COLUMN_TOTAL: cols_reg <= cfg_data;
                msa_pkg::CFG_CONST_MODE:   cmode_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    msa_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .cfg_clear(cfg_hit),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .out_ready(m_tready), .out_valid(m_tvalid),
        .stat(stat), .cmd(ctrl_cmd)
    );

    // The summary request clears the matrix state in the same cycle, so the next
    // element already starts a new matrix.
    always_comb
    begin
        cmd = ctrl_cmd;
        if (cfg_hit) cmd = '{take: 1'b0, col_emit: 1'b0, sum_emit: 1'b0, clear: 1'b1};
    end

    msa_datapath #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_dp (
        .clk(clk), .rst_n(rst_n), .element_bits(s_tdata),
        .row_total(rows_reg), .column_total(cols_reg), .constant_mode(cmode_reg),
        .cmd(cmd), .stat(stat), .result(result)
    );

    assign m_tuser = result[1:0];
    assign m_tdata = {5'd0, result[20:2]};
    assign m_tlast = result[21];

    // A summary request always carries run_end and no flag position.
    a_sum_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == msa_pkg::KIND_SUMMARY |-> m_tlast && m_tdata[4:0] == 5'd0)
        else $error("summary without run_end");
    // No element is taken while column flags or the summary are pending.
    a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_cmd.col_emit || ctrl_cmd.sum_emit |-> !s_tready)
        else $error("element taken during flag burst");
    // A clearing step never coincides with element intake.
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_cmd.clear |-> !ctrl_cmd.take)
        else $error("clear together with element intake");
endmodule
`default_nettype wire
